// File: hdl/raw_video_fragment_packetizer_unit_macros.svh
// Assertion macros for the raw video fragment packetizer
// No dependencies; included by the files that carry concurrent assertions
`ifndef RAW_VIDEO_FRAGMENT_PACKETIZER_UNIT_MACROS_SVH
`define RAW_VIDEO_FRAGMENT_PACKETIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define RVFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rvfp assertion failed");
// property checked on every clock edge, reset included
`define RVFP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("rvfp assertion failed");
`else
`define RVFP_ASSERT(lbl, clk, rst_n, prop)
`define RVFP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: hdl/rvfp_pkg.sv
// Shared types and constants of the raw video fragment packetizer
// No dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rvfp_pkg;

  localparam int unsigned OffsetW = 24;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SizeW   = 14;
  localparam int unsigned LineW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LppW    = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 14;

  localparam logic [SizeW-1:0] PayloadSizeRst = SizeW'(1468);
  localparam logic [LineW-1:0] FirstLine      = LineW'(1);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINES_PER_PACKET = 2'd0,
    CFG_PAYLOAD_SIZE     = 2'd1,
    CFG_LINE_TAIL_BYTES  = 2'd2,
    CFG_LAST_PIECE_INDEX = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [LppW-1:0]  lines_per_packet;
    logic [SizeW-1:0] payload_size;
    logic [SizeW-1:0] line_tail_bytes;
    logic [ByteW-1:0] last_piece_index;
  } rvfp_cfg_t;

  typedef struct packed {
    logic [OffsetW-1:0] frame_offset;
    logic [LineW-1:0]   current_line;
    logic [ByteW-1:0]   piece_counter;
    logic [ByteW-1:0]   sequence_counter;
  } rvfp_state_t;

  typedef struct packed {
    logic [OffsetW-1:0] byte_offset;
    logic [SizeW-1:0]   data_bytes;
    logic [SizeW-1:0]   pad_bytes;
    logic [ByteW-1:0]   sequence_number;
    logic [LineW-1:0]   line_no;
    logic [ByteW-1:0]   piece_index;
    logic               time_valid;
    logic [TimeW-1:0]   timestamp;
    logic               end_of_frame;
  } rvfp_desc_t;

endpackage

// File: hdl/rvfp_cfg_regs.sv
// Configuration register file of the packetizer
// Depends on rvfp_pkg
`timescale 1ns / 1ps

module rvfp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rvfp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rvfp_pkg::CfgDataW-1:0]  cfg_data_i,
  output rvfp_pkg::rvfp_cfg_t            cfg_o
);
  import rvfp_pkg::*;

  rvfp_cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_LINES_PER_PACKET: cfg_d.lines_per_packet = cfg_data_i[LppW-1:0];
        CFG_PAYLOAD_SIZE:     cfg_d.payload_size     = cfg_data_i[SizeW-1:0];
        CFG_LINE_TAIL_BYTES:  cfg_d.line_tail_bytes  = cfg_data_i[SizeW-1:0];
        CFG_LAST_PIECE_INDEX: cfg_d.last_piece_index = cfg_data_i[ByteW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lines_per_packet <= '0;
      cfg_q.payload_size     <= PayloadSizeRst;
      cfg_q.line_tail_bytes  <= '0;
      cfg_q.last_piece_index <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/rvfp_frag_calc.sv
// Fragment descriptor and next frame position for one packet request
// Depends on rvfp_pkg; purely combinational
`timescale 1ns / 1ps

module rvfp_frag_calc (
  input  rvfp_pkg::rvfp_cfg_t              cfg_i,
  input  rvfp_pkg::rvfp_state_t            state_i,
  input  logic [rvfp_pkg::OffsetW-1:0]     frame_bytes_i,
  input  logic [rvfp_pkg::TimeW-1:0]       frame_time_i,
  output rvfp_pkg::rvfp_desc_t             desc_o,
  output rvfp_pkg::rvfp_state_t            state_o
);
  import rvfp_pkg::*;

  logic               large_mode;
  logic               last_piece;
  logic [OffsetW-1:0] remaining;
  logic [SizeW-1:0]   piece_size;
  logic [SizeW-1:0]   size;
  logic               eof;
  logic               tv;

  // bytes left in the frame and the nominal piece size
  always_comb begin
    large_mode = (cfg_i.lines_per_packet == '0);
    last_piece = (state_i.piece_counter == cfg_i.last_piece_index);
    remaining  = (state_i.frame_offset < frame_bytes_i) ?
                 (frame_bytes_i - state_i.frame_offset) : '0;
    if (large_mode) begin
      piece_size = last_piece ? cfg_i.line_tail_bytes : cfg_i.payload_size;
    end else if (remaining < OffsetW'(cfg_i.payload_size)) begin
      piece_size = remaining[SizeW-1:0];
    end else begin
      piece_size = cfg_i.payload_size;
    end
  end

  // clamp at frame end, padding and timestamp
  always_comb begin
    eof  = (OffsetW'(piece_size) >= remaining);
    size = eof ? remaining[SizeW-1:0] : piece_size;
    tv   = large_mode ? (state_i.piece_counter == '0) : (state_i.current_line == FirstLine);

    desc_o.byte_offset     = state_i.frame_offset;
    desc_o.data_bytes      = size;
    desc_o.pad_bytes       = (size < cfg_i.payload_size) ? (cfg_i.payload_size - size) : '0;
    desc_o.sequence_number = state_i.sequence_counter;
    desc_o.line_no         = state_i.current_line;
    desc_o.piece_index     = large_mode ? state_i.piece_counter : '0;
    desc_o.time_valid      = tv;
    desc_o.timestamp       = tv ? frame_time_i : '0;
    desc_o.end_of_frame    = eof;
  end

  // frame position after this packet
  always_comb begin
    state_o                  = state_i;
    state_o.sequence_counter = state_i.sequence_counter + ByteW'(1);
    if (eof) begin
      state_o.frame_offset  = '0;
      state_o.current_line  = FirstLine;
      state_o.piece_counter = '0;
    end else begin
      state_o.frame_offset = state_i.frame_offset + OffsetW'(size);
      if (large_mode) begin
        if (last_piece) begin
          state_o.current_line = state_i.current_line + LineW'(1);
        end
        if (state_i.piece_counter < cfg_i.last_piece_index) begin
          state_o.piece_counter = state_i.piece_counter + ByteW'(1);
        end else begin
          state_o.piece_counter = '0;
        end
      end else begin
        state_o.current_line = state_i.current_line + LineW'(cfg_i.lines_per_packet);
      end
    end
  end

endmodule

// File: hdl/raw_video_fragment_packetizer_unit.sv
// A request accepted into the request register moves into the descriptor register when the
// output is not stalled, and the outputs are driven from the descriptor register.
// Throughput: one request per cycle while the output is not stalled; the frame position
// registers are updated together with the descriptor register on each transfer.
// Reset (asynchronous, active low): both stages empty, offset 0, line 1, piece 0,
// sequence 0, registers at 0 / 1468 / 0 / 0; configuration writes are taken every cycle.
`timescale 1ns / 1ps
`include "raw_video_fragment_packetizer_unit_macros.svh"

module raw_video_fragment_packetizer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rvfp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rvfp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rvfp_pkg::OffsetW-1:0]   frame_bytes_i,
  input  logic [rvfp_pkg::TimeW-1:0]     frame_time_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rvfp_pkg::OffsetW-1:0]   byte_offset_o,
  output logic [rvfp_pkg::SizeW-1:0]     data_bytes_o,
  output logic [rvfp_pkg::SizeW-1:0]     pad_bytes_o,
  output logic [rvfp_pkg::ByteW-1:0]     sequence_number_o,
  output logic [rvfp_pkg::LineW-1:0]     line_no_o,
  output logic [rvfp_pkg::ByteW-1:0]     piece_index_o,
  output logic                           time_valid_o,
  output logic [rvfp_pkg::TimeW-1:0]     timestamp_o,
  output logic                           end_of_frame_o
);
  import rvfp_pkg::*;

  rvfp_cfg_t          cfg;
  logic               in_valid_q;
  logic [OffsetW-1:0] frame_bytes_q;
  logic [TimeW-1:0]   frame_time_q;
  logic               out_valid_q;
  rvfp_desc_t         desc_q, desc_d;
  rvfp_state_t        state_q, state_d;
  logic               advance;
  logic               fire;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  rvfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // pipeline flow control
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      frame_bytes_q <= frame_bytes_i;
      frame_time_q  <= frame_time_i;
    end
  end

  // descriptor and next frame position
  rvfp_frag_calc u_calc (
    .cfg_i         (cfg),
    .state_i       (state_q),
    .frame_bytes_i (frame_bytes_q),
    .frame_time_i  (frame_time_q),
    .desc_o        (desc_d),
    .state_o       (state_d)
  );

  // frame position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.frame_offset     <= '0;
      state_q.current_line     <= FirstLine;
      state_q.piece_counter    <= '0;
      state_q.sequence_counter <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // descriptor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      desc_q <= desc_d;
    end
  end

  // output transaction
  assign out_valid_o       = out_valid_q;
  assign byte_offset_o     = desc_q.byte_offset;
  assign data_bytes_o      = desc_q.data_bytes;
  assign pad_bytes_o       = desc_q.pad_bytes;
  assign sequence_number_o = desc_q.sequence_number;
  assign line_no_o         = desc_q.line_no;
  assign piece_index_o     = desc_q.piece_index;
  assign time_valid_o      = desc_q.time_valid;
  assign timestamp_o       = desc_q.timestamp;
  assign end_of_frame_o    = desc_q.end_of_frame;

  // checks
  `RVFP_ASSERT(a_eof_restarts_frame, clk_i, rst_ni,
    fire && desc_d.end_of_frame |=>
      state_q.frame_offset == '0 && state_q.current_line == FirstLine)
  `RVFP_ASSERT(a_seq_steps_per_packet, clk_i, rst_ni,
    fire |=> state_q.sequence_counter == $past(state_q.sequence_counter) + ByteW'(1))
  `RVFP_ASSERT(a_pad_fills_payload, clk_i, rst_ni,
    out_valid_q && desc_q.data_bytes < cfg.payload_size |->
      desc_q.data_bytes + desc_q.pad_bytes == cfg.payload_size)
  `RVFP_ASSERT(a_full_stall_blocks_input, clk_i, rst_ni,
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
  `RVFP_ASSERT_ALWAYS(a_idle_state_holds, clk_i,
    !fire && rst_ni && $past(rst_ni) |=> $stable(state_q))

endmodule

// File: tb/tb_raw_video_fragment_packetizer_unit.sv
// Self-checking testbench for raw_video_fragment_packetizer_unit: directed and random requests
// Depends on rvfp_pkg and the packetizer top level; descriptors predicted by an in-bench model
`timescale 1ns / 1ps

module tb_raw_video_fragment_packetizer_unit;
  import rvfp_pkg::*;

  localparam int unsigned MaxFramePackets = 64;
  localparam logic [OffsetW-1:0] MaxFrameBytes = '1;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  cfg_reg_e            cfg_index_i   = CFG_LINES_PER_PACKET;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [OffsetW-1:0]  frame_bytes_i = '0;
  logic [TimeW-1:0]    frame_time_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [OffsetW-1:0]  byte_offset_o;
  logic [SizeW-1:0]    data_bytes_o;
  logic [SizeW-1:0]    pad_bytes_o;
  logic [ByteW-1:0]    sequence_number_o;
  logic [LineW-1:0]    line_no_o;
  logic [ByteW-1:0]    piece_index_o;
  logic                time_valid_o;
  logic [TimeW-1:0]    timestamp_o;
  logic                end_of_frame_o;

  // packetizer model: registers and frame position
  rvfp_cfg_t   model_cfg;
  rvfp_state_t model_state;
  rvfp_desc_t  pending_descs [$];
  int unsigned mismatch_count = 0;

  // idling controls
  bit          src_idle  = 1'b0;
  bit          sink_idle = 1'b0;
  int unsigned sink_gap  = 0;
  int unsigned sink_hold = 0;

  raw_video_fragment_packetizer_unit u_top (.*);

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // next packet descriptor of the current frame, advancing the model position
  function automatic rvfp_desc_t next_descriptor(input logic [OffsetW-1:0] frame_bytes,
                                                 input logic [TimeW-1:0]   frame_time);
    rvfp_desc_t  d;
    bit          large_mode;
    bit          at_tail;
    int unsigned left;
    int unsigned size;
    large_mode = (model_cfg.lines_per_packet == '0);
    at_tail    = (model_state.piece_counter == model_cfg.last_piece_index);
    left = (model_state.frame_offset < frame_bytes) ?
           int'(frame_bytes - model_state.frame_offset) : 0;
    if (large_mode) begin
      size = at_tail ? model_cfg.line_tail_bytes : model_cfg.payload_size;
    end else begin
      size = (left < model_cfg.payload_size) ? left : model_cfg.payload_size;
    end
    // fragment reaching or passing the frame end is clamped
    d.end_of_frame = (size >= left);
    if (d.end_of_frame) size = left;
    d.byte_offset     = model_state.frame_offset;
    d.data_bytes      = SizeW'(size);
    d.pad_bytes       = (size < model_cfg.payload_size) ?
                        SizeW'(model_cfg.payload_size - size) : '0;
    d.sequence_number = model_state.sequence_counter;
    d.line_no         = model_state.current_line;
    d.piece_index     = large_mode ? model_state.piece_counter : '0;
    d.time_valid      = large_mode ? (model_state.piece_counter == '0) :
                                     (model_state.current_line == FirstLine);
    d.timestamp       = d.time_valid ? frame_time : '0;

    model_state.sequence_counter += 1;
    if (d.end_of_frame) begin
      model_state.frame_offset  = '0;
      model_state.current_line  = FirstLine;
      model_state.piece_counter = '0;
    end else begin
      model_state.frame_offset += OffsetW'(size);
      if (large_mode) begin
        if (at_tail) model_state.current_line += 1;
        if (model_state.piece_counter < model_cfg.last_piece_index) begin
          model_state.piece_counter += 1;
        end else begin
          model_state.piece_counter = '0;
        end
      end else begin
        model_state.current_line += LineW'(model_cfg.lines_per_packet);
      end
    end
    return d;
  endfunction

  // one request transaction; valid is left high so the next request can follow at once
  task automatic send_request(input logic [OffsetW-1:0] frame_bytes,
                              input logic [TimeW-1:0] frame_time, output bit last_packet);
    int unsigned gap;
    rvfp_desc_t  d;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    frame_bytes_i <= frame_bytes;
    frame_time_i  <= frame_time;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    d = next_descriptor(frame_bytes, frame_time);
    pending_descs.push_back(d);
    last_packet = d.end_of_frame;
  endtask

  // requests for one frame until its end, or until the packet budget runs out
  task automatic send_frame(input logic [OffsetW-1:0] frame_bytes, output int unsigned sent);
    logic [TimeW-1:0] frame_time;
    bit               last_packet;
    frame_time = $urandom();
    sent = 0;
    do begin
      send_request(frame_bytes, frame_time, last_packet);
      sent++;
    end while (!last_packet && sent < MaxFramePackets);
  endtask

  // stop offering, wait for every outstanding descriptor, then stay idle before returning
  task automatic wait_all_descs();
    in_valid_i <= 1'b0;
    while (pending_descs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all four registers once the block is idle
  task automatic program_registers(input logic [LppW-1:0] lpp, input logic [SizeW-1:0] payload,
                                   input logic [SizeW-1:0] tail,
                                   input logic [ByteW-1:0] last_piece);
    cfg_reg_e            idx;
    logic [CfgDataW-1:0] value;
    wait_all_descs();
    idx = idx.first();
    repeat (4) begin
      case (idx)
        CFG_LINES_PER_PACKET: value = CfgDataW'(lpp);
        CFG_PAYLOAD_SIZE:     value = CfgDataW'(payload);
        CFG_LINE_TAIL_BYTES:  value = CfgDataW'(tail);
        default:              value = CfgDataW'(last_piece);
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= value;
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
    model_cfg = '{lines_per_packet: lpp, payload_size: payload,
                  line_tail_bytes: tail, last_piece_index: last_piece};
  endtask

  // reset register values, field extremes and zero sized pieces
  task automatic test_reset_state();
    bit last_packet;
    send_request(OffsetW'(1), $urandom(), last_packet);
    send_request(MaxFrameBytes, '1, last_packet);
    program_registers(4'd0, SizeW'(9000), SizeW'(9000), 8'd0);
    send_request(MaxFrameBytes, '1, last_packet);
    send_request(OffsetW'(1), '0, last_packet);
    send_request(OffsetW'(1), $urandom(), last_packet);
  endtask

  // clamped last fragment and a frame that shrank below the offset
  task automatic test_clamp_and_stale();
    bit last_packet;
    program_registers(4'd0, SizeW'(1000), SizeW'(500), 8'd3);
    send_request(OffsetW'(5000), $urandom(), last_packet);
    send_request(OffsetW'(5000), $urandom(), last_packet);
    send_request(OffsetW'(1000), $urandom(), last_packet);
    repeat (3) send_request(OffsetW'(2500), 32'h1234_5678, last_packet);
  endtask

  // empty tail piece, tail longer than the payload
  task automatic test_tail_pieces();
    bit last_packet;
    program_registers(4'd0, SizeW'(100), SizeW'(0), 8'd1);
    repeat (4) send_request(OffsetW'(1000), $urandom(), last_packet);
    program_registers(4'd0, SizeW'(100), SizeW'(9000), 8'd1);
    repeat (3) send_request(OffsetW'(20000), $urandom(), last_packet);
  endtask

  // piece counter left above a lowered last piece index
  task automatic test_piece_above_last();
    bit last_packet;
    program_registers(4'd0, SizeW'(200), SizeW'(50), 8'd5);
    repeat (3) send_request(OffsetW'(10000), $urandom(), last_packet);
    program_registers(4'd0, SizeW'(200), SizeW'(50), 8'd1);
    repeat (2) send_request(OffsetW'(10000), $urandom(), last_packet);
  endtask

  // whole lines per packet, last packet clipped
  task automatic test_small_raster();
    bit last_packet;
    program_registers(4'd2, SizeW'(1000), SizeW'(0), 8'd0);
    repeat (3) send_request(OffsetW'(2500), $urandom(), last_packet);
    program_registers(4'd15, SizeW'(9000), SizeW'(9000), 8'd255);
    send_request(OffsetW'(100), $urandom(), last_packet);
  endtask

  // one long frame of single bytes stepping the line counter by fifteen, back to back
  task automatic test_long_frame();
    bit last_packet;
    program_registers(4'd15, SizeW'(1), SizeW'(0), 8'd0);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (200) send_request(MaxFrameBytes, $urandom(), last_packet);
    send_request(OffsetW'(1), $urandom(), last_packet);
  endtask

  // receiver holds off while requests keep coming, then the sender waits for all results
  task automatic test_backpressure();
    int unsigned sent;
    program_registers(4'd3, SizeW'(64), SizeW'(0), 8'd0);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    sink_hold = 400;
    repeat (3) send_frame(OffsetW'(640), sent);
    wait_all_descs();
    sink_idle = 1'b1;
    program_registers(4'd0, SizeW'(32), SizeW'(10), 8'd2);
    sink_hold = 300;
    repeat (3) send_frame(OffsetW'(300), sent);
    wait_all_descs();
  endtask

  // random settings, mostly complete frames with some stray and broken requests
  task automatic test_random_phases();
    logic [LppW-1:0]  lpp;
    logic [SizeW-1:0] payload;
    logic [SizeW-1:0] tail;
    logic [ByteW-1:0] last_piece;
    int unsigned      sent;
    int unsigned      phase_items;
    int unsigned      span;
    bit               last_packet;
    repeat (12) begin
      lpp = $urandom_range(0, 1) ? '0 : LppW'($urandom_range(1, 15));
      case ($urandom_range(0, 5))
        0:       payload = SizeW'(1);
        1:       payload = SizeW'(9000);
        2:       payload = SizeW'($urandom_range(1, 9000));
        default: payload = SizeW'($urandom_range(1, 1500));
      endcase
      case ($urandom_range(0, 5))
        0:       tail = '0;
        1:       tail = SizeW'(9000);
        2:       tail = SizeW'($urandom_range(0, 9000));
        default: tail = SizeW'($urandom_range(0, payload));
      endcase
      case ($urandom_range(0, 5))
        0:       last_piece = 8'd255;
        1:       last_piece = 8'd0;
        default: last_piece = ByteW'($urandom_range(0, 7));
      endcase
      program_registers(lpp, payload, tail, last_piece);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      phase_items = 0;
      while (phase_items < 100) begin
        case ($urandom_range(0, 9))
          0: begin
            send_request(OffsetW'($urandom_range(1, MaxFrameBytes)), $urandom(), last_packet);
            phase_items++;
          end
          1: begin
            send_request(OffsetW'($urandom_range(1, 64)), $urandom(), last_packet);
            phase_items++;
          end
          default: begin
            span = model_cfg.payload_size * $urandom_range(1, 24);
            send_frame(OffsetW'($urandom_range(1, span)), sent);
            phase_items += sent;
          end
        endcase
      end
    end
  endtask

  // receiver: ready with random gaps after each transaction, or a long hold
  always @(posedge clk_i) begin : drive_sink
    if (out_valid_o && out_ready_i) sink_gap = sink_idle ? $urandom_range(0, 15) : 0;
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready_i <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each descriptor transaction with the oldest prediction
  always @(posedge clk_i) begin : check_descs
    rvfp_desc_t got;
    rvfp_desc_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {byte_offset_o, data_bytes_o, pad_bytes_o, sequence_number_o, line_no_o,
             piece_index_o, time_valid_o, timestamp_o, end_of_frame_o};
      if (pending_descs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected descriptor: %p", got);
      end else begin
        want = pending_descs.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"descriptor mismatch (expected/actual): offset %0d/%0d data %0d/%0d ",
                      "pad %0d/%0d seq %0d/%0d line %0d/%0d piece %0d/%0d tv %0b/%0b ",
                      "ts %h/%h eof %0b/%0b"},
                     want.byte_offset, got.byte_offset, want.data_bytes, got.data_bytes,
                     want.pad_bytes, got.pad_bytes, want.sequence_number,
                     got.sequence_number, want.line_no, got.line_no,
                     want.piece_index, got.piece_index, want.time_valid, got.time_valid,
                     want.timestamp, got.timestamp, want.end_of_frame, got.end_of_frame);
          end
        end
      end
    end
  end

  // test sequence
  initial begin : run_tests
    model_cfg   = '{lines_per_packet: '0, payload_size: PayloadSizeRst,
                    line_tail_bytes: '0, last_piece_index: '0};
    model_state = '{frame_offset: '0, current_line: FirstLine,
                    piece_counter: '0, sequence_counter: '0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_clamp_and_stale();
    test_tail_pieces();
    test_piece_above_last();
    test_small_raster();
    test_long_frame();
    test_backpressure();
    test_random_phases();
    wait_all_descs();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/rvfp_pkg.sv
hdl/rvfp_cfg_regs.sv
hdl/rvfp_frag_calc.sv
hdl/raw_video_fragment_packetizer_unit.sv
tb/tb_raw_video_fragment_packetizer_unit.sv
